>>> design/assert_macros.svh
// Assertion macros shared by the page diff run extractor RTL.
// Each macro expands to one labeled concurrent assertion on a clock and
// an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> design/pdre_pkg.sv
// Package for the page diff run extractor: field widths, limits, record kinds
// and the command and record structs passed between front, queue and back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdre_pkg;

  // Default geometry
  localparam int unsigned PageBytesDef    = 4096;
  localparam int unsigned QuarterShiftDef = 10;

  // Field widths
  localparam int unsigned StartW   = 12;
  localparam int unsigned LengthW  = 13;
  localparam int unsigned TotalW   = 12;
  localparam int unsigned BytesW   = 13;
  localparam int unsigned QuarterW = 10;

  // Saturation limits
  localparam logic [LengthW-1:0]  LengthMax  = '1;
  localparam logic [TotalW-1:0]   TotalMax   = '1;
  localparam logic [BytesW-1:0]   BytesMax   = '1;
  localparam logic [QuarterW-1:0] QuarterMax = '1;

  // Command queue depth
  localparam int unsigned QueueDepth = 4;

  // Stream widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 96;

  typedef enum logic {
    KIND_RUN     = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Work for the back part caused by one input item
  typedef struct packed {
    logic               has_run;
    logic               has_sum;
    logic [StartW-1:0]  start;
    logic [1:0]         quarter;
    logic [LengthW-1:0] length;
  } cmd_t;

  // Queue status seen by the top level and the back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One result record
  typedef struct packed {
    kind_e               kind;
    logic [StartW-1:0]   run_start;
    logic [LengthW-1:0]  run_length;
    logic [TotalW-1:0]   run_total;
    logic [BytesW-1:0]   diff_bytes;
    logic [QuarterW-1:0] q0;
    logic [QuarterW-1:0] q1;
    logic [QuarterW-1:0] q2;
    logic [QuarterW-1:0] q3;
    logic                page_done;
  } rec_t;

endpackage

`default_nettype wire

>>> design/page_diff_run_extractor_unit.sv
// Page diff run extractor: compares two page versions byte by byte and
// reports differing runs and a per-page summary.
// Usage:
//   The slave channel takes one byte pair per transaction in position order,
//   old_byte in tdata[7:0] and new_byte in tdata[15:8], PAGE_BYTES
//   transactions per page. The master channel gives run records
//   (tuser = 0) when a run of differing bytes closes, and one page summary
//   (tuser = 1, tlast = 1) after the final byte of each page. The final byte
//   may give a run record followed by the summary.
//   Throughput is one transaction per cycle on the slave side while the
//   queue is not full; the front part finishes each item in the cycle it is
//   accepted. A result passes through the command queue and then the output
//   register, and a summary from the same byte as a run record comes after it.
//   A four-entry command queue sits between front and back, so input keeps
//   flowing while the receiver stalls until the queue fills; then tready
//   drops and stays low until the back part drains an entry.
//   Reset clears the position, the open run, all counters, the queue and the
//   output valid flag; the block is ready as soon as reset is released.
// Depends on pdre_pkg, pdre_front, pdre_queue, pdre_back, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module page_diff_run_extractor_unit import pdre_pkg::*; #(
  parameter int unsigned PAGE_BYTES    = PageBytesDef,
  parameter int unsigned QUARTER_SHIFT = QuarterShiftDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [7:0] old_byte, [15:8] new_byte
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [11:0] run_start, [24:12] run_length, [36:25] run_total,
  // [49:37] diff_bytes, [59:50] quarter_zero_runs, [69:60] quarter_one_runs,
  // [79:70] quarter_two_runs, [89:80] quarter_three_runs, [95:90] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // [0] record_kind
  output logic [0:0]               m_axis_tuser_o,
  // page_done
  output logic                     m_axis_tlast_o
);

  cmd_t   cmd;
  cmd_t   head;
  qstat_t qstat;
  rec_t   rec;
  logic   push;
  logic   pop;
  logic   accept;

  assign s_axis_tready_o = !qstat.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  pdre_front #(
    .PAGE_BYTES    (PAGE_BYTES),
    .QUARTER_SHIFT (QUARTER_SHIFT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .old_byte_i (s_axis_tdata_i[7:0]),
    .new_byte_i (s_axis_tdata_i[15:8]),
    .cmd_o      (cmd),
    .push_o     (push)
  );

  pdre_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  pdre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .rec_o       (rec)
  );

  // Pack the record onto the master channel
  assign m_axis_tdata_o = {6'b0, rec.q3, rec.q2, rec.q1, rec.q0, rec.diff_bytes,
                           rec.run_total, rec.run_length, rec.run_start};
  assign m_axis_tuser_o = rec.kind;
  assign m_axis_tlast_o = rec.page_done;

  // Checks
  `ASSERT_IMPLIES(a_no_push_when_full, clk_i, rst_ni, push, !qstat.full)
  `ASSERT_IMPLIES(a_last_is_summary, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o,
                  m_axis_tuser_o == KIND_SUMMARY)
  `ASSERT_IMPLIES(a_run_nonempty, clk_i, rst_ni,
                  m_axis_tvalid_o && (m_axis_tuser_o == KIND_RUN), rec.run_length != '0)
  `ASSERT_NEXT(a_pop_needs_entry, clk_i, rst_ni, pop && qstat.empty, 1'b0)

endmodule

`default_nettype wire

>>> design/pdre_front.sv
// Front part: accepts byte pairs, tracks position and the open run, and
// pushes one command per item that closes a run or ends the page.
// Depends on pdre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdre_front import pdre_pkg::*; #(
  parameter int unsigned PAGE_BYTES    = PageBytesDef,
  parameter int unsigned QUARTER_SHIFT = QuarterShiftDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  old_byte_i,
  input  wire logic [7:0]  new_byte_i,
  output cmd_t             cmd_o,
  output logic             push_o
);

  localparam int unsigned PosW = $clog2(PAGE_BYTES);

  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    start_q, start_d;
  logic [LengthW-1:0] len_q, len_d;

  logic               differs;
  logic               last;
  logic               open;
  logic [PosW-1:0]    new_start;
  logic [LengthW-1:0] new_len;
  logic [31:0]        start_wide;
  logic [31:0]        quarter_wide;

  // Classify the current item
  assign differs = |(old_byte_i ^ new_byte_i);
  assign last    = 32'(pos_q) >= 32'(PAGE_BYTES - 1);
  assign open    = len_q != '0;

  // Extend or start the run
  always_comb begin
    if (differs && !open) begin
      new_start = pos_q;
      new_len   = LengthW'(1);
    end else if (differs) begin
      new_start = start_q;
      new_len   = (len_q == LengthMax) ? LengthMax : len_q + LengthW'(1);
    end else begin
      new_start = start_q;
      new_len   = len_q;
    end
  end

  assign start_wide   = 32'(new_start);
  assign quarter_wide = start_wide >> QUARTER_SHIFT;

  // Build the command for the back part
  always_comb begin
    cmd_o.has_run = differs ? last : open;
    cmd_o.has_sum = last;
    cmd_o.start   = start_wide[StartW-1:0];
    cmd_o.quarter = quarter_wide[1:0];
    cmd_o.length  = new_len;
  end

  assign push_o = accept_i && (cmd_o.has_run || cmd_o.has_sum);

  // Advance position and run state
  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    if (accept_i) begin
      if (last) begin
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
      end else begin
        pos_d   = pos_q + PosW'(1);
        start_d = new_start;
        len_d   = differs ? new_len : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

>>> design/pdre_queue.sv
// Short command queue between the front and the back parts.
// Depends on pdre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdre_queue import pdre_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire cmd_t   cmd_i,
  input  wire logic   pop_i,
  output cmd_t        head_o,
  output qstat_t      stat_o
);

  localparam int unsigned AddrW = $clog2(QueueDepth);

  cmd_t             entry_q [QueueDepth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]   count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = count_q == (AddrW + 1)'(QueueDepth);
  assign stat_o.empty = count_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AddrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AddrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (AddrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AddrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> design/pdre_back.sv
// Back part: drains commands, keeps the page counters and drives the
// output register with run records and page summaries.
// Depends on pdre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdre_back import pdre_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cmd_t   head_i,
  input  wire qstat_t stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output rec_t        rec_o
);

  logic                phase_q, phase_d;
  logic                valid_q, valid_d;
  rec_t                rec_q, rec_d;
  logic [TotalW-1:0]   runs_q, runs_d;
  logic [BytesW-1:0]   bytes_q, bytes_d;
  logic [QuarterW-1:0] quart_q [4];
  logic [QuarterW-1:0] quart_d [4];

  logic                take;
  logic                emit_run;
  logic [BytesW:0]     bytes_sum;

  assign take      = (!valid_q || out_ready_i) && !stat_i.empty;
  assign emit_run  = head_i.has_run && !phase_q;
  assign pop_o     = take && !(emit_run && head_i.has_sum);
  assign bytes_sum = {1'b0, bytes_q} + (BytesW + 1)'(head_i.length);

  // Select the next record and update counters
  always_comb begin
    phase_d = phase_q;
    runs_d  = runs_q;
    bytes_d = bytes_q;
    quart_d = quart_q;
    rec_d   = rec_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      rec_d   = '0;
      if (emit_run) begin
        rec_d.kind       = KIND_RUN;
        rec_d.run_start  = head_i.start;
        rec_d.run_length = head_i.length;
        runs_d  = (runs_q == TotalMax) ? TotalMax : runs_q + TotalW'(1);
        bytes_d = (bytes_sum > (BytesW + 1)'(BytesMax)) ? BytesMax : bytes_sum[BytesW-1:0];
        quart_d[head_i.quarter] = (quart_q[head_i.quarter] == QuarterMax) ?
                                  QuarterMax : quart_q[head_i.quarter] + QuarterW'(1);
        phase_d = head_i.has_sum;
      end else begin
        rec_d.kind       = KIND_SUMMARY;
        rec_d.run_total  = runs_q;
        rec_d.diff_bytes = (runs_q != '0) ? bytes_q : '0;
        rec_d.q0         = quart_q[0];
        rec_d.q1         = quart_q[1];
        rec_d.q2         = quart_q[2];
        rec_d.q3         = quart_q[3];
        rec_d.page_done  = 1'b1;
        runs_d  = '0;
        bytes_d = '0;
        for (int i = 0; i < 4; i++) begin
          quart_d[i] = '0;
        end
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      valid_q <= 1'b0;
      runs_q  <= '0;
      bytes_q <= '0;
      for (int i = 0; i < 4; i++) begin
        quart_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
      runs_q  <= runs_d;
      bytes_q <= bytes_d;
      quart_q <= quart_d;
    end
  end

  // Hold output payload
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire
